/* rtl/core/v3a_pkg.sv */
// Shared opcode type, word width and saturation helper for the vector ALU.
`timescale 1ns / 1ps
package v3a_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_NORM  = 3'd3,
    OP_DOT   = 3'd4,
    OP_CROSS = 3'd5
  } op_e;

  localparam int unsigned WordW = 32;

  // Clamp a wide signed value to the 32-bit range.
  function automatic logic [WordW-1:0] sat_word(input logic signed [71:0] v,
                                                output logic hit);
    logic signed [71:0] hi_lim;
    logic signed [71:0] lo_lim;
    hi_lim = 72'sd2147483647;
    lo_lim = -72'sd2147483648;
    hit = 1'b0;
    if (v > hi_lim) begin
      hit = 1'b1;
      sat_word = 32'h7fff_ffff;
    end else if (v < lo_lim) begin
      hit = 1'b1;
      sat_word = 32'h8000_0000;
    end else begin
      sat_word = v[WordW-1:0];
    end
  endfunction

endpackage

/* rtl/core/vec3_alu.sv */
// Top level of the three-component Q16.16 vector ALU.
//
// Items enter on the s_axis group: tdata holds op, a_x, a_y, a_z, b_x, b_y, b_z
// and scale, packed from the lowest bit up. Results leave on m_axis: tdata holds
// r_x, r_y, r_z, scalar_out, saturated and zero_length from the lowest bit up.
// Every accepted item gives exactly one result item, in order.
// The pipeline is FRAC_BITS + 3 register stages deep: one product stage,
// FRAC_BITS + 1 reciprocal square root stages (one quotient bit each; the sums
// and saturation of the other operations are done beside the first of them and
// carried alongside) and an output register; at Q16.16 the search covers the
// integer bit and every fraction bit. One item can enter in every cycle while
// the receiver does not stall; all operations travel through the same stages
// so that order is kept. Reset clears every valid bit and the pipeline empties.
// When the receiver stalls, the whole pipeline holds (one shared enable), so
// s_axis_tready is low only while the output register is full and not taken.
`timescale 1ns / 1ps
module vec3_alu import v3a_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], a_x, a_y, a_z, b_x, b_y, b_z, scale, zero fill to 232 bits.
  input  logic [231:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r_x, r_y, r_z, scalar_out, saturated, zero_length, zero fill to 136 bits.
  output logic [135:0] m_axis_tdata
);
  localparam int unsigned Lat = FRAC_BITS + 1;

  logic en;
  logic signed [31:0] a_in [3];
  logic signed [31:0] b_in [3];
  logic signed [31:0] s_in;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_in[k] = s_axis_tdata[3+32*k +: 32];
      b_in[k] = s_axis_tdata[99+32*k +: 32];
    end
    s_in = s_axis_tdata[195 +: 32];
  end

  // Stage 1: products.
  logic               v1;
  logic [2:0]         op1;
  logic signed [31:0] a1 [3];
  logic signed [31:0] b1 [3];
  logic signed [63:0] p1 [6];

  v3a_mul u_mul (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en),
    .vld_i (s_axis_tvalid && s_axis_tready), .op_i(s_axis_tdata[2:0]),
    .a_i(a_in), .b_i(b_in), .s_i(s_in),
    .vld_o(v1), .op_o(op1), .a_o(a1), .b_o(b1), .p_o(p1)
  );

  // Stage 2: floor shifts, sums and saturation; norm gets len2 and a^2.
  logic signed [71:0] w [3];
  logic               sat_d;
  logic               zl_d;
  logic [31:0]        r_d [3];
  logic [31:0]        sc_d;
  logic [65:0]        len2;
  logic signed [71:0] dsum;
  logic [2:0]         hit;
  logic               dhit;

  always_comb begin
    for (int k = 0; k < 3; k++) w[k] = '0;
    dsum = '0;
    len2 = 66'(p1[0]) + 66'(p1[1]) + 66'(p1[2]);
    case (op1)
      OP_ADD: for (int k = 0; k < 3; k++) w[k] = 72'(a1[k]) + 72'(b1[k]);
      OP_SUB: for (int k = 0; k < 3; k++) w[k] = 72'(a1[k]) - 72'(b1[k]);
      OP_SCALE: for (int k = 0; k < 3; k++) w[k] = 72'(p1[k]) >>> FRAC_BITS;
      OP_DOT: dsum = (72'(p1[0]) + 72'(p1[1]) + 72'(p1[2])) >>> FRAC_BITS;
      OP_CROSS: begin
        w[0] = (72'(p1[0]) - 72'(p1[1])) >>> FRAC_BITS;
        w[1] = (72'(p1[2]) - 72'(p1[3])) >>> FRAC_BITS;
        w[2] = (72'(p1[4]) - 72'(p1[5])) >>> FRAC_BITS;
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 3; k++) r_d[k] = sat_word(w[k], hit[k]);
    sc_d  = sat_word(dsum, dhit);
    sat_d = |hit || dhit;
    zl_d  = (op1 == OP_NORM) && (len2 == '0);
  end

  logic [Lat-1:0] vq;
  logic [31:0]    rq  [Lat][3];
  logic [31:0]    scq [Lat];
  logic [Lat-1:0] satq;
  logic [Lat-1:0] zlq;
  logic [Lat-1:0] nmq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[Lat-2:0], v1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rq[0]   <= r_d;
      scq[0]  <= sc_d;
      satq[0] <= sat_d;
      zlq[0]  <= zl_d;
      nmq[0]  <= (op1 == OP_NORM) && (len2 != '0);
      for (int s = 1; s < Lat; s++) begin
        rq[s]   <= rq[s-1];
        scq[s]  <= scq[s-1];
        satq[s] <= satq[s-1];
        zlq[s]  <= zlq[s-1];
        nmq[s]  <= nmq[s-1];
      end
    end
  end

  // Normalize lanes: one pipelined search per component.
  logic [31:0] nq [3];
  logic [2:0]  nneg;
  logic [65:0] len_safe;
  assign len_safe = (len2 == '0) ? 66'd1 : len2;

  for (genvar c = 0; c < 3; c++) begin : g_norm
    v3a_rsqrt #(.FracBits(FRAC_BITS)) u_rsqrt (
      .clk_i(clk_i), .en_i(en), .a2_i(p1[c]), .len2_i(len_safe),
      .neg_i(a1[c][31]), .q_o(nq[c]), .neg_o(nneg[c])
    );
  end

  // Output register: the last stage between pipeline and receiver.
  logic [31:0] rx_q, ry_q, rz_q, sco_q;
  logic        sat_q, zl_q, ov_q;
  logic [31:0] fin [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fin[k] = nmq[Lat-1] ? (nneg[k] ? -nq[k] : nq[k]) : rq[Lat-1][k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= vq[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q  <= fin[0];
      ry_q  <= fin[1];
      rz_q  <= fin[2];
      sco_q <= scq[Lat-1];
      sat_q <= satq[Lat-1];
      zl_q  <= zlq[Lat-1];
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, zl_q, sat_q, sco_q, rz_q, ry_q, rx_q};

  logic unused;
  assign unused = |s_axis_tdata[231:227];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output item changed under stall");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[128] && m_axis_tdata[129]))
    else $error("saturated and zero-length together");
  a_zl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[129] |-> m_axis_tdata[127:0] == '0)
    else $error("zero-length result not zero");
endmodule

/* rtl/core/v3a_mul.sv */
// Product stage: combinational operand selection, then registered 32x32 products.
`timescale 1ns / 1ps
module v3a_mul import v3a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [2:0]        op_i,
  input  logic signed [31:0] a_i [3],
  input  logic signed [31:0] b_i [3],
  input  logic signed [31:0] s_i,
  output logic              vld_o,
  output logic [2:0]        op_o,
  output logic signed [31:0] a_o [3],
  output logic signed [31:0] b_o [3],
  output logic signed [63:0] p_o [6]
);
  logic signed [31:0] x_d [6];
  logic signed [31:0] y_d [6];

  // Product lanes: scale uses lanes 0..2, dot/norm use 0..2 as a*b or a*a,
  // cross uses all six.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      x_d[k] = '0;
      y_d[k] = '0;
    end
    case (op_i)
      OP_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          x_d[k] = a_i[k];
          y_d[k] = s_i;
        end
      end
      OP_NORM: begin
        for (int k = 0; k < 3; k++) begin
          x_d[k] = a_i[k];
          y_d[k] = a_i[k];
        end
      end
      OP_DOT: begin
        for (int k = 0; k < 3; k++) begin
          x_d[k] = a_i[k];
          y_d[k] = b_i[k];
        end
      end
      OP_CROSS: begin
        x_d[0] = a_i[1]; y_d[0] = b_i[2];
        x_d[1] = a_i[2]; y_d[1] = b_i[1];
        x_d[2] = a_i[2]; y_d[2] = b_i[0];
        x_d[3] = a_i[0]; y_d[3] = b_i[2];
        x_d[4] = a_i[0]; y_d[4] = b_i[1];
        x_d[5] = a_i[1]; y_d[5] = b_i[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_o <= op_i;
      a_o  <= a_i;
      b_o  <= b_i;
      for (int k = 0; k < 6; k++) begin
        p_o[k] <= x_d[k] * y_d[k];
      end
    end
  end
endmodule

/* rtl/core/v3a_rsqrt.sv */
// Pipelined search for floor(|a| * 2^F / sqrt(len2)), one quotient bit a stage.
`timescale 1ns / 1ps
module v3a_rsqrt #(
  parameter int unsigned FracBits = 16
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a2_i,
  input  logic [65:0] len2_i,
  input  logic        neg_i,
  output logic [31:0] q_o,
  output logic        neg_o
);
  localparam int unsigned Steps = FracBits + 1;
  localparam int unsigned QW    = FracBits + 1;
  localparam int unsigned PW    = 64 + 2 * FracBits;
  localparam int unsigned MW    = FracBits + 67;
  localparam int unsigned CW    = 2 * FracBits + 70;

  logic [QW-1:0] q_q  [Steps];
  logic [PW-1:0] p_q  [Steps];
  logic [MW-1:0] m_q  [Steps];
  logic [63:0]   a2_q [Steps];
  logic [65:0]   l_q  [Steps];
  logic          n_q  [Steps];

  // Each stage tests one quotient bit: (q + 2^b)^2 * len2 <= a^2 << 2F.
  // The products q^2 * len2 and q * len2 travel with q, so each test needs
  // only shifts, one three-input add and a compare.
  for (genvar g = 0; g < Steps; g++) begin : g_step
    localparam int unsigned Bit = FracBits - g;
    logic [QW-1:0] q_in;
    logic [PW-1:0] p_in;
    logic [MW-1:0] m_in;
    logic [63:0]   a2_in;
    logic [65:0]   l_in;
    logic          n_in;
    logic [CW-1:0] cand;
    logic          take;

    if (g == 0) begin : g_first
      assign q_in  = '0;
      assign p_in  = '0;
      assign m_in  = '0;
      assign a2_in = a2_i;
      assign l_in  = len2_i;
      assign n_in  = neg_i;
    end else begin : g_next
      assign q_in  = q_q[g-1];
      assign p_in  = p_q[g-1];
      assign m_in  = m_q[g-1];
      assign a2_in = a2_q[g-1];
      assign l_in  = l_q[g-1];
      assign n_in  = n_q[g-1];
    end

    always_comb begin
      cand = CW'(p_in) + (CW'(m_in) << (Bit + 1)) + (CW'(l_in) << (2 * Bit));
      take = cand <= CW'({a2_in, {(2*FracBits){1'b0}}});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[g]  <= take ? (q_in | (QW'(1) << Bit)) : q_in;
        p_q[g]  <= take ? cand[PW-1:0] : p_in;
        m_q[g]  <= take ? (m_in + (MW'(l_in) << Bit)) : m_in;
        a2_q[g] <= a2_in;
        l_q[g]  <= l_in;
        n_q[g]  <= n_in;
      end
    end
  end

  assign q_o   = 32'(q_q[Steps-1]);
  assign neg_o = n_q[Steps-1];
endmodule

/* tb/vec3_alu_tb.sv */
// Self-checking testbench for the three-component fixed-point vector ALU.
`timescale 1ns / 1ps
module vec3_alu_tb;
  import v3a_pkg::*;

  localparam int unsigned Frac      = 16;
  localparam int unsigned NumRandom = 900;
  localparam int unsigned StallMax  = 2000;
  localparam int unsigned Drain     = 40;

  // One input item and one result item, at the widths of the block.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scale;
  } vec_item_t;

  typedef struct packed {
    logic signed [31:0] r_x, r_y, r_z, scalar_out;
    logic               saturated, zero_length;
  } vec_result_t;

  // Clamp to 32 bits and remember whether anything was clamped.
  function automatic logic signed [31:0] clamp32(input logic signed [71:0] v,
                                                 inout logic hit);
    if (v > 72'sd2147483647) begin
      hit = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -72'sd2147483648) begin
      hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Largest q with q*q*len2 <= a*a * 2^(2*Frac), sign of a restored.
  function automatic logic signed [31:0] unit_comp(input logic signed [31:0] a,
                                                   input logic [63:0] len2);
    logic [63:0]  mag;
    logic [127:0] bound;
    logic [127:0] lhs;
    logic [63:0]  q;
    logic [63:0]  t;
    mag   = a < 0 ? 64'(-64'(a)) : 64'(a);
    bound = 128'(mag * mag) << (2 * Frac);
    q     = '0;
    for (int b = Frac; b >= 0; b--) begin
      t   = q | (64'd1 << b);
      lhs = 128'(t * t) * 128'(len2);
      if (lhs <= bound) q = t;
    end
    return a < 0 ? -32'(q) : 32'(q);
  endfunction

  function automatic vec_result_t compute_vec(input vec_item_t it);
    vec_result_t        r;
    logic signed [71:0] av[3], bv[3], acc;
    logic [63:0]        len2;
    logic               hit;
    r   = '0;
    hit = 1'b0;
    av[0] = it.a_x; av[1] = it.a_y; av[2] = it.a_z;
    bv[0] = it.b_x; bv[1] = it.b_y; bv[2] = it.b_z;
    case (it.op)
      OP_ADD: begin
        r.r_x = clamp32(av[0] + bv[0], hit);
        r.r_y = clamp32(av[1] + bv[1], hit);
        r.r_z = clamp32(av[2] + bv[2], hit);
      end
      OP_SUB: begin
        r.r_x = clamp32(av[0] - bv[0], hit);
        r.r_y = clamp32(av[1] - bv[1], hit);
        r.r_z = clamp32(av[2] - bv[2], hit);
      end
      OP_SCALE: begin
        // Arithmetic shift of the exact product rounds toward minus infinity.
        r.r_x = clamp32((av[0] * 72'(it.scale)) >>> Frac, hit);
        r.r_y = clamp32((av[1] * 72'(it.scale)) >>> Frac, hit);
        r.r_z = clamp32((av[2] * 72'(it.scale)) >>> Frac, hit);
      end
      OP_NORM: begin
        len2 = 64'(av[0] * av[0]) + 64'(av[1] * av[1]) + 64'(av[2] * av[2]);
        if (len2 == 0) begin
          r.zero_length = 1'b1;
        end else begin
          r.r_x = unit_comp(it.a_x, len2);
          r.r_y = unit_comp(it.a_y, len2);
          r.r_z = unit_comp(it.a_z, len2);
        end
      end
      OP_DOT: begin
        // Summed exactly, rounded once.
        acc = av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2];
        r.scalar_out = clamp32(acc >>> Frac, hit);
      end
      OP_CROSS: begin
        r.r_x = clamp32((av[1] * bv[2] - av[2] * bv[1]) >>> Frac, hit);
        r.r_y = clamp32((av[2] * bv[0] - av[0] * bv[2]) >>> Frac, hit);
        r.r_z = clamp32((av[0] * bv[1] - av[1] * bv[0]) >>> Frac, hit);
      end
      default: ;
    endcase
    r.saturated = hit;
    return r;
  endfunction

  // Holds the predicted results in order of acceptance.
  class vec_scoreboard;
    vec_result_t pending[$];

    function void note_item(input vec_item_t it);
      pending.push_back(compute_vec(it));
    endfunction

    // Returns 1 when the result matches; msg lists the wrong fields otherwise.
    function bit check_result(input vec_result_t got, output string msg);
      vec_result_t exp;
      msg = "";
      if (pending.size() == 0) begin
        msg = "result with nothing pending";
        return 1'b0;
      end
      exp = pending.pop_front();
      if (got.r_x != exp.r_x)
        msg = {msg, $sformatf(" r_x %h/%h", got.r_x, exp.r_x)};
      if (got.r_y != exp.r_y)
        msg = {msg, $sformatf(" r_y %h/%h", got.r_y, exp.r_y)};
      if (got.r_z != exp.r_z)
        msg = {msg, $sformatf(" r_z %h/%h", got.r_z, exp.r_z)};
      if (got.scalar_out != exp.scalar_out)
        msg = {msg, $sformatf(" scalar %h/%h", got.scalar_out, exp.scalar_out)};
      if (got.saturated != exp.saturated)
        msg = {msg, $sformatf(" sat %b/%b", got.saturated, exp.saturated)};
      if (got.zero_length != exp.zero_length)
        msg = {msg, $sformatf(" zl %b/%b", got.zero_length, exp.zero_length)};
      return msg == "";
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;

  vec_scoreboard sb = new();
  int unsigned   n_errors = 0;
  int unsigned   n_sent = 0;
  int unsigned   n_results = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   op_count[8];
  bit            steady = 1'b0;  // no idling on either side while set

  vec3_alu dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    n_errors++;
    $display("MISMATCH at %0t:%s", $realtime, msg);
  endtask

  // Receiver: stalls at random about 12 percent of the time, never while steady is set.
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk_i) begin
    vec_result_t got;
    string       msg;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{r_x: m_axis_tdata[31:0], r_y: m_axis_tdata[63:32],
              r_z: m_axis_tdata[95:64], scalar_out: m_axis_tdata[127:96],
              saturated: m_axis_tdata[128], zero_length: m_axis_tdata[129]};
      n_results++;
      if (!sb.check_result(got, msg)) report(msg);
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallMax) begin
      $display("** vec3_alu: FAILED **");
      $finish;
    end
  end

  // Sends one item, with an occasional idle gap before it.
  task automatic send_item(input vec_item_t it);
    while (!steady && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, it.scale, it.b_z, it.b_y, it.b_x,
                     it.a_z, it.a_y, it.a_x, it.op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
    op_count[it.op]++;
    n_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
      6, 7:       return $signed($urandom_range(0, 32'h03ff_ffff)) - 32'sh0200_0000;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sh0001_0000;
          3: return -32'sh1;
          default: return 32'sh0;
        endcase
      end
    endcase
  endfunction

  function automatic vec_item_t pick_item();
    vec_item_t it;
    it.op = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
    it.a_x = pick_word(); it.a_y = pick_word(); it.a_z = pick_word();
    it.b_x = pick_word(); it.b_y = pick_word(); it.b_z = pick_word();
    it.scale = pick_word();
    if (it.op == OP_NORM && $urandom_range(0, 9) == 0) begin
      it.a_x = '0; it.a_y = '0; it.a_z = '0;
    end
    return it;
  endfunction

  localparam logic signed [31:0] Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] Min = 32'sh8000_0000;
  localparam logic signed [31:0] One = 32'sh0001_0000;

  initial begin
    vec_item_t directed[$];
    directed = '{
      '{OP_ADD,   Max, Min, 0,   Max, Min, -1,  0},    // add saturates both ways
      '{OP_ADD,   1,   -1,  One, 2,   3,   4,   0},
      '{OP_SUB,   Min, Max, 0,   Max, Min, 1,   0},    // subtract saturates
      '{OP_SUB,   0,   0,   0,   Min, Max, -1,  0},
      '{OP_SCALE, Max, Min, One, 0,   0,   0,   Max},  // scale by largest factor
      '{OP_SCALE, Max, Min, -1,  0,   0,   0,   Min},
      '{OP_SCALE, -3,  3,   One, 0,   0,   0,   1},    // rounding toward minus inf
      '{OP_NORM,  0,   0,   0,   1,   2,   3,   4},    // zero-length vector
      '{OP_NORM,  One, 0,   0,   0,   0,   0,   0},
      '{OP_NORM,  Min, Min, Min, 0,   0,   0,   0},
      '{OP_NORM,  Max, -1,  1,   0,   0,   0,   0},
      '{OP_NORM,  0,   0,   -1,  0,   0,   0,   0},
      '{OP_DOT,   Max, Max, Max, Max, Max, Max, 0},    // dot saturates high
      '{OP_DOT,   Min, Min, Min, Max, Max, Max, 0},
      '{OP_DOT,   One, 2*One, -One, 3, -5, 7,   0},
      '{OP_CROSS, Max, Min, Max, Min, Max, Min, 0},
      '{OP_CROSS, One, 0,   0,   0,   One, 0,   0},
      '{OP_CROSS, -1,  1,   -1,  1,   -1,  1,   0},
      '{3'd6,     Max, Min, 1,   2,   3,   4,   5},    // undefined opcodes
      '{3'd7,     -1,  -1,  -1,  -1,  -1,  -1,  -1}
    };
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_item(directed[i]);
    for (int i = 0; i < NumRandom; i++) begin
      steady = (i >= 300 && i < 450);
      send_item(pick_item());
    end
    steady = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results.", n_sent, n_results);
    $display("By op: add %0d, sub %0d, scale %0d, norm %0d, dot %0d, cross %0d, other %0d",
             op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
             op_count[5], op_count[6] + op_count[7]);
    if (n_errors == 0) begin
      $display("** vec3_alu: PASSED **");
    end else begin
      $display("** vec3_alu: FAILED **");
    end
    $finish;
  end

endmodule
